// ===== src/box_clip_frustum_test_macros.svh =====
// Assertion macros shared by the checker of the box culling block.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef BOX_CLIP_FRUSTUM_TEST_MACROS_SVH
`define BOX_CLIP_FRUSTUM_TEST_MACROS_SVH

// Clocked property that is switched off while reset is asserted.
`define BCFT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("bcft check failed");

// Same, with a message of the caller's choosing.
`define BCFT_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

`endif

// ===== src/bcft_pkg.sv =====
// Types, widths and helper functions of the box culling block.
// Has no dependencies; imported by every module of the block.
`default_nettype none

package bcft_pkg;

	localparam int WORD_W    = 64;
	localparam int VAL_W     = 32;
	localparam int PROD_W    = 64;
	localparam int SUM_W     = 68;
	localparam int NUM_CFG   = 8;
	localparam int CFG_IDX_W = 3;
	localparam int PLANES    = 6;
	localparam int ENTRIES   = 16;
	localparam int CORNERS   = 8;

	typedef logic signed [VAL_W-1:0]  val_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [WORD_W-1:0]        word_t;

	// Clamps a wide value to the signed 32-bit range.
	function automatic val_t sat_val(input sum_t v);
		val_t r;
		if (v[SUM_W-1:VAL_W-1] == '0 || v[SUM_W-1:VAL_W-1] == '1) begin
			r = v[VAL_W-1:0];
		end else if (v[SUM_W-1]) begin
			r = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(VAL_W-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic val_t half_of(input word_t w, input logic hi);
		return hi ? val_t'(w[WORD_W-1:VAL_W]) : val_t'(w[VAL_W-1:0]);
	endfunction

endpackage

`default_nettype wire

// ===== src/bcft_if.sv =====
// Handshake channels of the box culling block: box and transform in, verdict out.
// Depends on nothing.
`default_nettype none

interface bcft_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] bounds_min_xy;
	logic [63:0] bounds_min_z_max_x;
	logic [63:0] bounds_max_yz;
	logic [63:0] transform_pair_0;
	logic [63:0] transform_pair_1;
	logic [63:0] transform_pair_2;
	logic [63:0] transform_pair_3;
	logic [63:0] transform_pair_4;
	logic [63:0] transform_pair_5;
	logic [63:0] transform_pair_6;
	logic [63:0] transform_pair_7;

	modport source (output valid, bounds_min_xy, bounds_min_z_max_x, bounds_max_yz,
		transform_pair_0, transform_pair_1, transform_pair_2, transform_pair_3,
		transform_pair_4, transform_pair_5, transform_pair_6, transform_pair_7,
		input ready);
	modport sink (input valid, bounds_min_xy, bounds_min_z_max_x, bounds_max_yz,
		transform_pair_0, transform_pair_1, transform_pair_2, transform_pair_3,
		transform_pair_4, transform_pair_5, transform_pair_6, transform_pair_7,
		output ready);
endinterface

interface bcft_out_if;
	logic       valid;
	logic       ready;
	logic       visible;
	logic [5:0] rejecting_planes;

	modport source (output valid, visible, rejecting_planes, input ready);
	modport sink (input valid, visible, rejecting_planes, output ready);
endinterface

`default_nettype wire

// ===== src/box_clip_frustum_test.sv =====
// Box-against-frustum culling in clip space, fixed point, fully pipelined.
// Depends on bcft_pkg, bcft_if and bcft_matmul.
//
// A box (min and max corners) and its object transform arrive as one word on
// in_ch. The view-projection matrix sits in eight 64-bit registers written
// through cfg_we, cfg_index and cfg_data; the user must load them only while
// no word is in flight, which the block does not enforce. It multiplies the
// two matrices, projects the box extents along each axis and sums them into
// the clip coordinates of all eight corners, then tests the six planes.
//
// One verdict word leaves on out_ch per box, once it has passed the product,
// matrix, extent, clip and plane registers. A new box is taken in every
// cycle while out_ch is not stalled; the rate is set by the five register
// stages, each of which finishes one box per cycle. When out_ch is stalled
// the whole pipeline holds and in_ch.ready drops, so nothing is lost or
// repeated. Reset clears the valid bits and the matrix registers.
`default_nettype none

module box_clip_frustum_test import bcft_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0]    cfg_data,
	bcft_in_if.sink                   in_ch,
	bcft_out_if.source                out_ch
);

	word_t vp_q [NUM_CFG];
	word_t tr_w [NUM_CFG];
	val_t  vp [ENTRIES];
	val_t  tr [ENTRIES];
	val_t  bnd_in [2][3];
	val_t  bnd_s1 [2][3];
	val_t  bnd_s2 [2][3];
	val_t  m_s2 [ENTRIES];
	logic  en;
	logic  v_s2;
	logic  v_s3;
	logic  v_s4;
	logic  v_s5;
	prod_t ax_s3 [4][3][2];
	val_t  w_s3 [4];
	sum_t  clip_c [CORNERS][4];
	val_t  clip_s4 [CORNERS][4];
	logic [PLANES-1:0] rej_c;
	logic [PLANES-1:0] planes_s5;

	assign en = !v_s5 || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) begin
				vp_q[i] <= '0;
			end
		end else if (cfg_we) begin
			vp_q[cfg_index] <= cfg_data;
		end
	end

	assign tr_w[0] = in_ch.transform_pair_0;
	assign tr_w[1] = in_ch.transform_pair_1;
	assign tr_w[2] = in_ch.transform_pair_2;
	assign tr_w[3] = in_ch.transform_pair_3;
	assign tr_w[4] = in_ch.transform_pair_4;
	assign tr_w[5] = in_ch.transform_pair_5;
	assign tr_w[6] = in_ch.transform_pair_6;
	assign tr_w[7] = in_ch.transform_pair_7;

	always_comb begin
		for (int e = 0; e < ENTRIES; e++) begin
			vp[e] = half_of(vp_q[e/2], 1'(e % 2));
			tr[e] = half_of(tr_w[e/2], 1'(e % 2));
		end
		bnd_in[0][0] = half_of(in_ch.bounds_min_xy, 1'b0);
		bnd_in[0][1] = half_of(in_ch.bounds_min_xy, 1'b1);
		bnd_in[0][2] = half_of(in_ch.bounds_min_z_max_x, 1'b0);
		bnd_in[1][0] = half_of(in_ch.bounds_min_z_max_x, 1'b1);
		bnd_in[1][1] = half_of(in_ch.bounds_max_yz, 1'b0);
		bnd_in[1][2] = half_of(in_ch.bounds_max_yz, 1'b1);
	end

	bcft_matmul #(
		.FRAC_BITS(FRAC_BITS)
	) u_matmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (in_ch.valid),
		.vp        (vp),
		.tr        (tr),
		.valid_out (v_s2),
		.m_s2      (m_s2)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			bnd_s1 <= bnd_in;
			bnd_s2 <= bnd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Each row of the combined matrix times each axis extent, min and max.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				for (int k = 0; k < 3; k++) begin
					for (int h = 0; h < 2; h++) begin
						ax_s3[r][k][h] <= m_s2[k*4+r] * bnd_s2[h][k];
					end
				end
				w_s3[r] <= m_s2[12+r];
			end
		end
	end

	always_comb begin
		for (int n = 0; n < CORNERS; n++) begin
			for (int r = 0; r < 4; r++) begin
				clip_c[n][r] = SUM_W'(ax_s3[r][0][n%2]) + SUM_W'(ax_s3[r][1][(n/2)%2])
					+ SUM_W'(ax_s3[r][2][(n/4)%2]) + (SUM_W'(w_s3[r]) <<< FRAC_BITS);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < CORNERS; n++) begin
				for (int r = 0; r < 4; r++) begin
					clip_s4[n][r] <= sat_val(clip_c[n][r] >>> FRAC_BITS);
				end
			end
		end
	end

	always_comb begin
		rej_c = '1;
		for (int n = 0; n < CORNERS; n++) begin
			for (int k = 0; k < 3; k++) begin
				rej_c[2*k] = rej_c[2*k]
					& ((VAL_W+1)'(clip_s4[n][k]) < -((VAL_W+1)'(clip_s4[n][3])));
				rej_c[2*k+1] = rej_c[2*k+1] & (clip_s4[n][k] > clip_s4[n][3]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			planes_s5 <= rej_c;
		end
	end

	assign out_ch.valid            = v_s5;
	assign out_ch.visible          = (planes_s5 == '0);
	assign out_ch.rejecting_planes = planes_s5;

endmodule

`default_nettype wire

// ===== src/bcft_matmul.sv =====
// Two-stage product of the view-projection and object matrices.
// Depends on bcft_pkg; used by box_clip_frustum_test.
`default_nettype none

module bcft_matmul import bcft_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_in,
	input  wire val_t vp [ENTRIES],
	input  wire val_t tr [ENTRIES],
	output logic      valid_out,
	output val_t      m_s2 [ENTRIES]
);

	prod_t prod_s1 [ENTRIES][4];
	logic  v_s1;
	logic  v_s2;
	sum_t  sum_c [ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
		end
	end

	// Entry index is column * 4 + row.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				for (int r = 0; r < 4; r++) begin
					for (int k = 0; k < 4; k++) begin
						prod_s1[c*4+r][k] <= vp[k*4+r] * tr[c*4+k];
					end
				end
			end
		end
	end

	always_comb begin
		for (int e = 0; e < ENTRIES; e++) begin
			sum_c[e] = SUM_W'(prod_s1[e][0]) + SUM_W'(prod_s1[e][1])
				+ SUM_W'(prod_s1[e][2]) + SUM_W'(prod_s1[e][3]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < ENTRIES; e++) begin
				m_s2[e] <= sat_val(sum_c[e] >>> FRAC_BITS);
			end
		end
	end

	assign valid_out = v_s2;

endmodule

`default_nettype wire

// ===== src/bcft_checker.sv =====
// Port-level checks of the box culling block, bound to its top level.
// Depends on box_clip_frustum_test_macros.svh and box_clip_frustum_test.
`default_nettype none
`include "box_clip_frustum_test_macros.svh"

module bcft_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       visible,
	input wire logic [5:0] rejecting_planes
);

	`BCFT_ASSERT_MSG(a_verdict, clk, arst_n, out_valid |-> (visible == (rejecting_planes == 6'd0)), "visible disagrees with the plane mask")
	`BCFT_ASSERT(a_ready_follows_out, clk, arst_n, in_ready == (!out_valid || out_ready))
	`BCFT_ASSERT_MSG(a_hold, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(rejecting_planes)), "stalled word changed")

endmodule

bind box_clip_frustum_test bcft_checker u_bcft_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_ch.valid),
	.in_ready         (in_ch.ready),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.visible          (out_ch.visible),
	.rejecting_planes (out_ch.rejecting_planes)
);

`default_nettype wire

// ===== dv/box_clip_frustum_test_checker.sv =====
// Checker of the box culling block: predicts the plane verdict of every accepted box.
// Depends on bcft_pkg and bcft_if; instantiated beside the block by the testbench top.
`default_nettype none

module box_clip_frustum_test_checker import bcft_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0] cfg_data,
	bcft_in_if                     in_ch,
	bcft_out_if                    out_ch,
	output int                     fail_count,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       visible;
		logic [5:0] planes;
	} verdict_t;

	word_t    vp_regs [NUM_CFG];
	verdict_t verdicts[$];

	function automatic longint sval(input word_t w, input bit hi);
		logic signed [31:0] h;
		h = hi ? w[63:32] : w[31:0];
		return longint'(h);
	endfunction

	// Exact sum of products, floored by the fraction bits, clamped to 32 bits.
	function automatic longint fx_dot(input longint a[4], input longint b[4]);
		logic signed [79:0] acc;
		logic signed [79:0] q;
		acc = 0;
		for (int i = 0; i < 4; i++) acc += 80'(a[i]) * 80'(b[i]);
		q = acc >>> FRAC_BITS;
		if (q > 80'sh7FFFFFFF) return 64'sh7FFFFFFF;
		if (q < -80'sh80000000) return -64'sh80000000;
		return longint'(q);
	endfunction

	function automatic verdict_t cull_box(input word_t f[11]);
		longint vp[16], tr[16], m[4][4], lo[3], hi[3], row[4], col[4], v[4], cl[4];
		logic [5:0] rej, bits;
		verdict_t r;
		rej = 6'h3F;
		for (int e = 0; e < 16; e++) begin
			vp[e] = sval(vp_regs[e/2], e[0]);
			tr[e] = sval(f[3 + e/2], e[0]);
		end
		lo[0] = sval(f[0], 0); lo[1] = sval(f[0], 1); lo[2] = sval(f[1], 0);
		hi[0] = sval(f[1], 1); hi[1] = sval(f[2], 0); hi[2] = sval(f[2], 1);
		for (int r2 = 0; r2 < 4; r2++)
			for (int c = 0; c < 4; c++) begin
				for (int k = 0; k < 4; k++) begin
					row[k] = vp[k*4 + r2];
					col[k] = tr[c*4 + k];
				end
				m[r2][c] = fx_dot(row, col);
			end
		for (int n = 0; n < 8; n++) begin
			v[0] = n[0] ? hi[0] : lo[0];
			v[1] = n[1] ? hi[1] : lo[1];
			v[2] = n[2] ? hi[2] : lo[2];
			v[3] = 64'sd1 <<< FRAC_BITS;
			for (int r2 = 0; r2 < 4; r2++) begin
				for (int k = 0; k < 4; k++) row[k] = m[r2][k];
				cl[r2] = fx_dot(row, v);
			end
			bits = '0;
			for (int k = 0; k < 3; k++) begin
				if (cl[k] < -cl[3]) bits[2*k] = 1'b1;
				if (cl[k] > cl[3]) bits[2*k+1] = 1'b1;
			end
			rej &= bits;
		end
		r.visible = (rej == 0);
		r.planes  = rej;
		return r;
	endfunction

	assign pending = verdicts.size();

	always @(posedge clk or negedge arst_n) begin
		word_t    f[11];
		verdict_t exp_v;
		int       errs;
		errs = 0;
		if (!arst_n) begin
			foreach (vp_regs[i]) vp_regs[i] <= '0;
			verdicts.delete();
			fail_count <= 0;
		end else begin
			if (cfg_we) vp_regs[cfg_index] <= cfg_data;
			if (in_ch.valid && in_ch.ready) begin
				f = '{in_ch.bounds_min_xy, in_ch.bounds_min_z_max_x, in_ch.bounds_max_yz,
					in_ch.transform_pair_0, in_ch.transform_pair_1, in_ch.transform_pair_2,
					in_ch.transform_pair_3, in_ch.transform_pair_4, in_ch.transform_pair_5,
					in_ch.transform_pair_6, in_ch.transform_pair_7};
				verdicts.insert(verdicts.size(), cull_box(f));
			end
			if (out_ch.valid && out_ch.ready) begin
				if (verdicts.size() == 0) begin
					$display("%0t: unexpected word: visible %b planes %b", $time,
						out_ch.visible, out_ch.rejecting_planes);
					errs++;
				end else begin
					exp_v = verdicts.pop_front();
					if (out_ch.visible !== exp_v.visible) begin
						$display("%0t: visible expected %b actual %b", $time,
							exp_v.visible, out_ch.visible);
						errs++;
					end
					if (out_ch.rejecting_planes !== exp_v.planes) begin
						$display("%0t: planes expected %b actual %b", $time,
							exp_v.planes, out_ch.rejecting_planes);
						errs++;
					end
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
		end
	end
endmodule

`default_nettype wire

// ===== dv/box_clip_frustum_test_tb.sv =====
// Top of the box culling testbench: clock, reset, register writes and box stimulus.
// Depends on bcft_pkg, bcft_if, the block and box_clip_frustum_test_checker.
`default_nettype none

module box_clip_frustum_test_tb import bcft_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  ONE      = 32'h0001_0000;
	localparam int  LIMIT    = 1_000_000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;
	int                   fail_count;
	int                   pending;
	int                   cycles;
	int                   idle_pct;

	bcft_in_if  in_ch();
	bcft_out_if out_ch();

	box_clip_frustum_test dut (.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_ch(in_ch.sink), .out_ch(out_ch.source));

	box_clip_frustum_test_checker chk (.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_ch, .out_ch, .fail_count, .pending);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= idle_pct);

	function automatic word_t pack2(input int lo_v, input int hi_v);
		return {hi_v[31:0], lo_v[31:0]};
	endfunction

	function automatic int rnd_val();
		case ($urandom_range(5))
			0: return $urandom();
			1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return int'($urandom_range(8 * ONE)) - 4 * ONE;
		endcase
	endfunction

	function automatic int rnd_entry();
		case ($urandom_range(7))
			0: return $urandom();
			1: return 0;
			2: return ONE;
			default: return int'($urandom_range(4 * ONE)) - 2 * ONE;
		endcase
	endfunction

	task automatic write_reg(input int idx, input word_t d);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx[CFG_IDX_W-1:0];
		cfg_data  <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_matrix(input int m[16]);
		for (int k = 0; k < NUM_CFG; k++) write_reg(k, pack2(m[2*k], m[2*k+1]));
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic send_box(input int b[6], input int t[16]);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid              <= 1'b1;
		in_ch.bounds_min_xy      <= pack2(b[0], b[1]);
		in_ch.bounds_min_z_max_x <= pack2(b[2], b[3]);
		in_ch.bounds_max_yz      <= pack2(b[4], b[5]);
		in_ch.transform_pair_0   <= pack2(t[0], t[1]);
		in_ch.transform_pair_1   <= pack2(t[2], t[3]);
		in_ch.transform_pair_2   <= pack2(t[4], t[5]);
		in_ch.transform_pair_3   <= pack2(t[6], t[7]);
		in_ch.transform_pair_4   <= pack2(t[8], t[9]);
		in_ch.transform_pair_5   <= pack2(t[10], t[11]);
		in_ch.transform_pair_6   <= pack2(t[12], t[13]);
		in_ch.transform_pair_7   <= pack2(t[14], t[15]);
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic identity(output int m[16]);
		for (int e = 0; e < 16; e++) m[e] = (e % 5 == 0) ? ONE : 0;
	endtask

	// Well-formed box of random extent near the origin, at times made inverted along x.
	task automatic sane_box(output int b[6]);
		int c, h;
		for (int a = 0; a < 3; a++) begin
			c = int'($urandom_range(6 * ONE)) - 3 * ONE;
			h = $urandom_range(ONE);
			b[a]     = c - h;
			b[a + 3] = c + h;
		end
		if ($urandom_range(9) == 0) begin
			b[0] = b[3] + 1;
		end
	endtask

	task automatic run_phase(input int count, input int vp[16]);
		int b[6], t[16];
		load_matrix(vp);
		for (int i = 0; i < count; i++) begin
			if (i >= count / 3 && i < count / 2) idle_pct = 0;
			else idle_pct = 37;
			identity(t);
			if ($urandom_range(3) == 0) begin
				for (int e = 0; e < 16; e++) t[e] = rnd_entry();
			end else begin
				t[12] = int'($urandom_range(4 * ONE)) - 2 * ONE;
				t[13] = int'($urandom_range(4 * ONE)) - 2 * ONE;
				t[14] = int'($urandom_range(4 * ONE)) - 2 * ONE;
			end
			if ($urandom_range(4) == 0) begin
				for (int a = 0; a < 6; a++) b[a] = rnd_val();
			end else begin
				sane_box(b);
			end
			send_box(b, t);
		end
		drain();
	endtask

	initial begin
		int vp[16], t[16], b[6];
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		idle_pct    = 37;
		in_ch.valid = 1'b0;
		in_ch.bounds_min_xy = '0; in_ch.bounds_min_z_max_x = '0; in_ch.bounds_max_yz = '0;
		in_ch.transform_pair_0 = '0; in_ch.transform_pair_1 = '0;
		in_ch.transform_pair_2 = '0; in_ch.transform_pair_3 = '0;
		in_ch.transform_pair_4 = '0; in_ch.transform_pair_5 = '0;
		in_ch.transform_pair_6 = '0; in_ch.transform_pair_7 = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		identity(vp);
		load_matrix(vp);
		identity(t);
		// Directed boxes: inside, beyond each plane, straddling, inverted, extreme values.
		for (int p = 0; p < 6; p++) begin
			b = '{-ONE/4, -ONE/4, -ONE/4, ONE/4, ONE/4, ONE/4};
			b[p % 3]     += (p < 3 ? -3 : 3) * ONE;
			b[p % 3 + 3] += (p < 3 ? -3 : 3) * ONE;
			send_box(b, t);
		end
		b = '{-ONE/2, -ONE/2, -ONE/2, ONE/2, ONE/2, ONE/2};
		send_box(b, t);
		b = '{-3*ONE, -3*ONE, -3*ONE, 3*ONE, 3*ONE, 3*ONE};
		send_box(b, t);
		b = '{2*ONE, 0, 0, -2*ONE, 0, 0};
		send_box(b, t);
		b = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
		send_box(b, t);
		b = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
		send_box(b, t);
		b = '{-1, -1, -1, -1, -1, -1};
		send_box(b, t);
		for (int e = 0; e < 16; e++) t[e] = 32'h8000_0000;
		send_box(b, t);
		for (int e = 0; e < 16; e++) t[e] = 32'h7FFF_FFFF;
		send_box(b, t);
		for (int e = 0; e < 16; e++) t[e] = 0;
		send_box(b, t);
		identity(t);
		t[15] = -ONE;
		b = '{-ONE/4, -ONE/4, -ONE/4, ONE/4, ONE/4, ONE/4};
		send_box(b, t);
		drain();

		// Phases: zero matrix, extreme matrices, identity, random ones.
		vp = '{default: 0};
		run_phase(60, vp);
		vp = '{default: 32'h7FFF_FFFF};
		run_phase(60, vp);
		vp = '{default: 32'h8000_0000};
		run_phase(60, vp);
		identity(vp);
		run_phase(400, vp);
		for (int r = 0; r < 3; r++) begin
			identity(vp);
			for (int e = 0; e < 16; e++)
				if ($urandom_range(2) == 0) vp[e] = rnd_entry();
			if (r == 2) begin
				for (int e = 0; e < 16; e++) vp[e] = $urandom();
			end
			run_phase(200, vp);
		end

		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

`default_nettype wire

// ===== box_clip_frustum_test.f =====
+incdir+src
src/bcft_pkg.sv
src/bcft_if.sv
src/bcft_matmul.sv
src/box_clip_frustum_test.sv
src/bcft_checker.sv
dv/box_clip_frustum_test_checker.sv
dv/box_clip_frustum_test_tb.sv
